[rtl/core/rlkpm_pkg.sv]
`timescale 1ns / 1ps
package rlkpm_pkg;

	localparam int MEM_BYTES_DEF    = 4096;
	localparam int REGION_BYTES_DEF = 512;
	localparam int REGION_COUNT_DEF = 8;
	localparam int KEY_SLOTS_DEF    = 8;
	localparam int ACCESS_BYTES_DEF = 8;

	localparam int ADDR_W  = 12;
	localparam int SPAN_W  = 13;
	localparam int LANES   = 8;
	localparam int LANE_W  = 3;
	localparam int DATA_W  = 64;
	localparam int KEY_W   = 32;
	localparam int PAIRS   = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [2:0] CMD_READ        = 3'd0;
	localparam logic [2:0] CMD_WRITE       = 3'd1;
	localparam logic [2:0] CMD_LOCK        = 3'd2;
	localparam logic [2:0] CMD_UNLOCK      = 3'd3;
	localparam logic [2:0] CMD_ERASE       = 3'd4;
	localparam logic [2:0] CMD_READ_MIRROR = 3'd5;
	localparam logic [2:0] CMD_LOCK_MAP    = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_DENIED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ON  = 3'd5;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_READ_MIRROR,
		OP_WRITE,
		OP_ERASE
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_RUN,
		BK_ERASE
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic [1:0]        status;
		logic [ADDR_W-1:0] byte_address;
		logic [2:0]        region_num;
		logic [DATA_W-1:0] write_bytes;
		logic [3:0]        byte_count;
		logic [7:0]        lock_map;
	} op_entry_t;

endpackage

[rtl/core/rlkpm_if.sv]
`timescale 1ns / 1ps
interface rlkpm_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [11:0]        byte_address;
	logic [2:0]         region_num;
	logic [63:0]        write_bytes;
	logic [3:0]         byte_count;
	logic signed [31:0] access_key;
	logic               key_given;

	modport source (output valid, cmd, byte_address, region_num, write_bytes, byte_count,
		access_key, key_given, input ready);
	modport sink (input valid, cmd, byte_address, region_num, write_bytes, byte_count,
		access_key, key_given, output ready);
endinterface

interface rlkpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] read_bytes;
	logic [3:0]  read_count;
	logic [7:0]  lock_map;

	modport source (output valid, status, read_bytes, read_count, lock_map, input ready);
	modport sink (input valid, status, read_bytes, read_count, lock_map, output ready);
endinterface

[rtl/core/region_locked_key_protected_memory.sv]
`timescale 1ns / 1ps
// read, write, lock, unlock and lock map requests pass the front register, the queue,
// memory read register and output register; one request per cycle sustained while
// rsp.ready holds and no walk runs; the two-entry queue decouples front and back;
// an erase holds the back end, one memory row per cycle; after reset a clearing pass
// zeroes both memories and blocks requests; lock map and configuration reset to zero
module region_locked_key_protected_memory #(
	parameter int MEM_BYTES    = rlkpm_pkg::MEM_BYTES_DEF,
	parameter int REGION_BYTES = rlkpm_pkg::REGION_BYTES_DEF,
	parameter int REGION_COUNT = rlkpm_pkg::REGION_COUNT_DEF,
	parameter int KEY_SLOTS    = rlkpm_pkg::KEY_SLOTS_DEF,
	parameter int ACCESS_BYTES = rlkpm_pkg::ACCESS_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rlkpm_req_if.sink                         req,
	rlkpm_rsp_if.source                       rsp,
	input  logic                              cfg_write,
	input  logic [rlkpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlkpm_pkg::DATA_W-1:0]      cfg_data
);

	logic [rlkpm_pkg::PAIRS-1:0][rlkpm_pkg::DATA_W-1:0] key_pairs_q;
	logic [3:0]           keys_in_use_q;
	logic                 mirror_on_q;

	logic                 clearing;
	logic                 q_full;
	logic                 push;
	rlkpm_pkg::op_entry_t push_entry;
	logic                 pop;
	logic                 head_v;
	rlkpm_pkg::op_entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pairs_q   <= '0;
			keys_in_use_q <= 4'd0;
			mirror_on_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rlkpm_pkg::REG_KEY_PAIR_A:  key_pairs_q[0] <= cfg_data;
				rlkpm_pkg::REG_KEY_PAIR_B:  key_pairs_q[1] <= cfg_data;
				rlkpm_pkg::REG_KEY_PAIR_C:  key_pairs_q[2] <= cfg_data;
				rlkpm_pkg::REG_KEY_PAIR_D:  key_pairs_q[3] <= cfg_data;
				rlkpm_pkg::REG_KEYS_IN_USE: keys_in_use_q  <= cfg_data[3:0];
				rlkpm_pkg::REG_MIRROR_ON:   mirror_on_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rlkpm_front #(
		.MEM_BYTES    (MEM_BYTES),
		.REGION_BYTES (REGION_BYTES),
		.REGION_COUNT (REGION_COUNT),
		.KEY_SLOTS    (KEY_SLOTS),
		.ACCESS_BYTES (ACCESS_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.clearing    (clearing),
		.key_pairs   (key_pairs_q),
		.keys_in_use (keys_in_use_q),
		.q_full      (q_full),
		.push        (push),
		.entry       (push_entry)
	);

	rlkpm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_v     (head_v),
		.head       (head)
	);

	rlkpm_back #(
		.MEM_BYTES    (MEM_BYTES),
		.REGION_BYTES (REGION_BYTES),
		.REGION_COUNT (REGION_COUNT),
		.ACCESS_BYTES (ACCESS_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_v    (head_v),
		.head      (head),
		.pop       (pop),
		.mirror_on (mirror_on_q),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule

[rtl/core/rlkpm_front.sv]
`timescale 1ns / 1ps
module rlkpm_front #(
	parameter int MEM_BYTES    = rlkpm_pkg::MEM_BYTES_DEF,
	parameter int REGION_BYTES = rlkpm_pkg::REGION_BYTES_DEF,
	parameter int REGION_COUNT = rlkpm_pkg::REGION_COUNT_DEF,
	parameter int KEY_SLOTS    = rlkpm_pkg::KEY_SLOTS_DEF,
	parameter int ACCESS_BYTES = rlkpm_pkg::ACCESS_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rlkpm_req_if.sink             req,
	input  logic                  clearing,
	input  logic [rlkpm_pkg::PAIRS-1:0][rlkpm_pkg::DATA_W-1:0] key_pairs,
	input  logic [3:0]            keys_in_use,
	input  logic                  q_full,
	output logic                  push,
	output rlkpm_pkg::op_entry_t  entry
);

	localparam int RB_LOG = $clog2(REGION_BYTES);
	localparam int SH     = rlkpm_pkg::SPAN_W + RB_LOG;
	localparam int MW     = SH - RB_LOG + 2;
	localparam int PW     = rlkpm_pkg::SPAN_W + MW;
	localparam longint MUL = (longint'(1) << SH) / REGION_BYTES + 1;
	localparam logic [MW-1:0] MUL_C = MW'(MUL);
	localparam logic [31:0] MEM_W = 32'(MEM_BYTES);

	logic                               s1_v_q;
	logic [2:0]                         cmd_s1;
	logic [rlkpm_pkg::ADDR_W-1:0]       addr_s1;
	logic [2:0]                         region_s1;
	logic [rlkpm_pkg::DATA_W-1:0]       data_s1;
	logic [3:0]                         cnt_s1;
	logic                               key_ok_s1;
	logic [rlkpm_pkg::SPAN_W-1:0]       qa_s1;
	logic [rlkpm_pkg::SPAN_W-1:0]       qb_s1;
	logic [7:0]                         lock_q;

	logic                               accept;
	logic [rlkpm_pkg::SPAN_W-1:0]       span_first;
	logic [rlkpm_pkg::SPAN_W-1:0]       span_last;
	logic [PW-1:0]                      prod_first;
	logic [PW-1:0]                      prod_last;
	logic [3:0]                         keys_eff;
	logic                               key_hit;

	logic [31:0]                        a32;
	logic [31:0]                        end32;
	logic [31:0]                        room;
	logic [3:0]                         cap;
	logic [3:0]                         rd_cnt;
	logic                               reg_ok;
	logic [7:0]                         region_bit;
	logic                               locked;

	assign req.ready = !clearing && (!s1_v_q || !q_full);
	assign accept    = req.valid && req.ready;
	assign push      = s1_v_q && !q_full;

	// region quotient of first and last byte by reciprocal multiply
	assign span_first = rlkpm_pkg::SPAN_W'(req.byte_address);
	assign span_last  = rlkpm_pkg::SPAN_W'(req.byte_address)
		+ rlkpm_pkg::SPAN_W'(req.byte_count) - rlkpm_pkg::SPAN_W'(1);
	assign prod_first = PW'(span_first) * PW'(MUL_C);
	assign prod_last  = PW'(span_last) * PW'(MUL_C);

	assign keys_eff = (keys_in_use > 4'(KEY_SLOTS)) ? 4'(KEY_SLOTS) : keys_in_use;

	always_comb begin
		key_hit = 1'b0;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			if (4'(k) < keys_eff
				&& key_pairs[k >> 1][rlkpm_pkg::KEY_W * (k & 1) +: rlkpm_pkg::KEY_W]
				== rlkpm_pkg::KEY_W'(req.access_key))
				key_hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			lock_q <= 8'd0;
		end else begin
			if (accept)
				s1_v_q <= 1'b1;
			else if (push)
				s1_v_q <= 1'b0;
			if (push)
				lock_q <= entry.lock_map;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.cmd;
			addr_s1   <= req.byte_address;
			region_s1 <= req.region_num;
			data_s1   <= req.write_bytes;
			cnt_s1    <= req.byte_count;
			key_ok_s1 <= req.key_given && key_hit;
			qa_s1     <= rlkpm_pkg::SPAN_W'(prod_first >> SH);
			qb_s1     <= rlkpm_pkg::SPAN_W'(prod_last >> SH);
		end
	end

	assign a32        = 32'(addr_s1);
	assign end32      = a32 + 32'(cnt_s1);
	assign room       = MEM_W - a32;
	assign cap        = (cnt_s1 > 4'(ACCESS_BYTES)) ? 4'(ACCESS_BYTES) : cnt_s1;
	assign rd_cnt     = (room < 32'(cap)) ? 4'(room) : cap;
	assign reg_ok     = 4'(region_s1) < 4'(REGION_COUNT);
	assign region_bit = 8'(1) << region_s1;
	assign locked     = (qa_s1 < rlkpm_pkg::SPAN_W'(REGION_COUNT)) && lock_q[qa_s1[2:0]];

	always_comb begin
		entry              = '0;
		entry.op           = rlkpm_pkg::OP_NONE;
		entry.status       = rlkpm_pkg::ST_OK;
		entry.byte_address = addr_s1;
		entry.region_num   = region_s1;
		entry.write_bytes  = data_s1;
		entry.byte_count   = 4'd0;
		entry.lock_map     = lock_q;
		unique case (cmd_s1)
			rlkpm_pkg::CMD_READ, rlkpm_pkg::CMD_READ_MIRROR: begin
				if (a32 < MEM_W) begin
					entry.op = (cmd_s1 == rlkpm_pkg::CMD_READ) ? rlkpm_pkg::OP_READ
						: rlkpm_pkg::OP_READ_MIRROR;
					entry.byte_count = rd_cnt;
				end
			end
			rlkpm_pkg::CMD_WRITE: begin
				priority if (a32 >= MEM_W) begin
					entry.status = rlkpm_pkg::ST_INVALID;
				end else if (cnt_s1 == 4'd0) begin
					entry.status = rlkpm_pkg::ST_OK;
				end else if (cnt_s1 > 4'(ACCESS_BYTES) || end32 > MEM_W || qa_s1 != qb_s1) begin
					entry.status = rlkpm_pkg::ST_INVALID;
				end else if (locked && !key_ok_s1) begin
					entry.status = rlkpm_pkg::ST_DENIED;
				end else begin
					entry.op         = rlkpm_pkg::OP_WRITE;
					entry.byte_count = cnt_s1;
				end
			end
			rlkpm_pkg::CMD_LOCK: begin
				if (reg_ok)
					entry.lock_map = lock_q | region_bit;
				else
					entry.status = rlkpm_pkg::ST_INVALID;
			end
			rlkpm_pkg::CMD_UNLOCK: begin
				if (reg_ok)
					entry.lock_map = lock_q & ~region_bit;
				else
					entry.status = rlkpm_pkg::ST_INVALID;
			end
			rlkpm_pkg::CMD_ERASE: begin
				if (reg_ok)
					entry.op = rlkpm_pkg::OP_ERASE;
				else
					entry.status = rlkpm_pkg::ST_INVALID;
			end
			rlkpm_pkg::CMD_LOCK_MAP: begin
				entry.status = rlkpm_pkg::ST_OK;
			end
			default: begin
				entry.status = rlkpm_pkg::ST_INVALID;
			end
		endcase
	end

endmodule

[rtl/core/rlkpm_fifo.sv]
`timescale 1ns / 1ps
module rlkpm_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rlkpm_pkg::op_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_v,
	output rlkpm_pkg::op_entry_t head
);

	rlkpm_pkg::op_entry_t slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;

	assign full   = fill_q == 2'd2;
	assign head_v = fill_q != 2'd0;
	assign head   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

[rtl/core/rlkpm_back.sv]
`timescale 1ns / 1ps
module rlkpm_back #(
	parameter int MEM_BYTES    = rlkpm_pkg::MEM_BYTES_DEF,
	parameter int REGION_BYTES = rlkpm_pkg::REGION_BYTES_DEF,
	parameter int REGION_COUNT = rlkpm_pkg::REGION_COUNT_DEF,
	parameter int ACCESS_BYTES = rlkpm_pkg::ACCESS_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_v,
	input  rlkpm_pkg::op_entry_t head,
	output logic                 pop,
	input  logic                 mirror_on,
	output logic                 clearing,
	rlkpm_rsp_if.source          rsp
);

	localparam int LANES = rlkpm_pkg::LANES;
	localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
	localparam int RW    = $clog2(ROWS);
	localparam int AHW   = rlkpm_pkg::ADDR_W - rlkpm_pkg::LANE_W;
	localparam int RXW   = ((RW > AHW) ? RW : AHW) + 1;
	localparam int EW    = $clog2(MEM_BYTES + REGION_COUNT * REGION_BYTES + 1);

	rlkpm_pkg::bk_state_t state_q, state_d;

	logic [RW-1:0]  row_q;
	logic [RW-1:0]  last_row_q;
	logic [EW-1:0]  lo_q;
	logic [EW-1:0]  hi_q;
	logic           walk_mir_q;

	logic           r2_v_q;
	rlkpm_pkg::op_t op_s2;
	logic [1:0]     status_s2;
	logic [3:0]     cnt_s2;
	logic [2:0]     off_s2;
	logic [7:0]     lock_s2;

	logic           out_v_q;
	logic [1:0]     out_status_q;
	logic [63:0]    out_bytes_q;
	logic [3:0]     out_count_q;
	logic [7:0]     out_lock_q;

	logic           walk_active;
	logic           walk_done;
	logic           r2_adv;
	logic           start_erase;
	logic [EW-1:0]  ers_lo;
	logic [EW-1:0]  ers_raw;
	logic [EW-1:0]  ers_hi;
	logic           is_read;
	logic [7:0]     main_rd [LANES];
	logic [7:0]     mir_rd [LANES];
	logic [63:0]    rd_bytes;

	assign r2_adv   = !out_v_q || rsp.ready;
	assign clearing = state_q == rlkpm_pkg::BK_CLEAR;
	assign ers_lo   = EW'(head.region_num) * EW'(REGION_BYTES);
	assign ers_raw  = ers_lo + EW'(REGION_BYTES);
	assign ers_hi   = (ers_raw > EW'(MEM_BYTES)) ? EW'(MEM_BYTES) : ers_raw;
	assign is_read  = head.op == rlkpm_pkg::OP_READ || head.op == rlkpm_pkg::OP_READ_MIRROR;

	always_comb begin
		state_d     = state_q;
		walk_active = 1'b0;
		walk_done   = row_q == last_row_q;
		pop         = 1'b0;
		start_erase = 1'b0;
		unique case (state_q)
			rlkpm_pkg::BK_CLEAR, rlkpm_pkg::BK_ERASE: begin
				walk_active = 1'b1;
				if (walk_done)
					state_d = rlkpm_pkg::BK_RUN;
			end
			rlkpm_pkg::BK_RUN: begin
				pop = head_v && (!r2_v_q || r2_adv);
				if (pop && head.op == rlkpm_pkg::OP_ERASE && ers_lo < EW'(MEM_BYTES)) begin
					start_erase = 1'b1;
					state_d     = rlkpm_pkg::BK_ERASE;
				end
			end
			default: begin
				state_d = rlkpm_pkg::BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rlkpm_pkg::BK_CLEAR;
			row_q      <= '0;
			last_row_q <= RW'(ROWS - 1);
			lo_q       <= '0;
			hi_q       <= EW'(MEM_BYTES);
			walk_mir_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (start_erase) begin
				row_q      <= RW'(ers_lo >> rlkpm_pkg::LANE_W);
				last_row_q <= RW'((ers_hi - EW'(1)) >> rlkpm_pkg::LANE_W);
				lo_q       <= ers_lo;
				hi_q       <= ers_hi;
				walk_mir_q <= mirror_on;
			end else if (walk_active && !walk_done) begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		logic [7:0]    main_mem [ROWS];
		logic [7:0]    mir_mem [ROWS];
		logic [2:0]    boff;
		logic [RXW-1:0] row_wide;
		logic [RW-1:0] row_sel;
		logic [EW-1:0] walk_addr;
		logic          walk_hit;
		logic          wr_hit;
		logic          main_we;
		logic          mir_we;
		logic [RW-1:0] waddr;
		logic [7:0]    wdata;
		logic [7:0]    main_rd_s2;
		logic [7:0]    mir_rd_s2;

		assign boff      = 3'(b) - head.byte_address[2:0];
		assign row_wide  = RXW'(head.byte_address[rlkpm_pkg::ADDR_W-1:rlkpm_pkg::LANE_W])
			+ RXW'(3'(b) < head.byte_address[2:0]);
		assign row_sel   = row_wide[RW-1:0];
		assign walk_addr = EW'({row_q, 3'(b)});
		assign walk_hit  = walk_addr >= lo_q && walk_addr < hi_q;
		assign wr_hit    = pop && head.op == rlkpm_pkg::OP_WRITE && {1'b0, boff} < head.byte_count;
		assign main_we   = walk_active ? walk_hit : wr_hit;
		assign mir_we    = walk_active ? (walk_hit && walk_mir_q) : (wr_hit && mirror_on);
		assign waddr     = walk_active ? row_q : row_sel;
		assign wdata     = walk_active ? 8'd0 : head.write_bytes[{boff, 3'b000} +: 8];

		always_ff @(posedge clk) begin
			if (main_we)
				main_mem[waddr] <= wdata;
			if (pop)
				main_rd_s2 <= main_mem[row_sel];
		end

		always_ff @(posedge clk) begin
			if (mir_we)
				mir_mem[waddr] <= wdata;
			if (pop)
				mir_rd_s2 <= mir_mem[row_sel];
		end

		assign main_rd[b] = main_rd_s2;
		assign mir_rd[b]  = mir_rd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop)
				r2_v_q <= 1'b1;
			else if (r2_adv)
				r2_v_q <= 1'b0;
			if (r2_v_q && r2_adv)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2     <= head.op;
			status_s2 <= head.status;
			cnt_s2    <= is_read ? head.byte_count : 4'd0;
			off_s2    <= head.byte_address[2:0];
			lock_s2   <= head.lock_map;
		end
		if (r2_v_q && r2_adv) begin
			out_status_q <= status_s2;
			out_bytes_q  <= rd_bytes;
			out_count_q  <= cnt_s2;
			out_lock_q   <= lock_s2;
		end
	end

	// rotate lanes back into request byte order, zero past the count
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [2:0] idx;
			logic [7:0] sel;
			idx = off_s2 + 3'(i);
			sel = (op_s2 == rlkpm_pkg::OP_READ_MIRROR) ? mir_rd[idx] : main_rd[idx];
			rd_bytes[8 * i +: 8] = (4'(i) < cnt_s2) ? sel : 8'd0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_bytes = out_bytes_q;
	assign rsp.read_count = out_count_q;
	assign rsp.lock_map   = out_lock_q;

	a_no_issue_while_walking: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rlkpm_pkg::BK_RUN) |-> !pop)
		else $error("request issued during clearing or erase walk");

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rlkpm_pkg::BK_RUN) |-> (row_q <= last_row_q))
		else $error("walk row past its last row");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_count_q <= 4'(ACCESS_BYTES)))
		else $error("read count above access size");

	a_zero_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_bytes_q >> {out_count_q, 3'b000}) == 64'd0))
		else $error("read bytes beyond count not zero");

	a_erase_row_rise: assert property (@(posedge clk) disable iff (!arst_n)
		start_erase |=> (state_q == rlkpm_pkg::BK_ERASE && lo_q < EW'(MEM_BYTES)))
		else $error("erase walk started outside memory");

endmodule
